[src/gnps_pkg.sv]
// ----------------------------------------------------------------------------
// gnps_pkg: shared types and constants of the grid nearest probe search
// Configuration record, command queue entry, mode and register codes.
// ----------------------------------------------------------------------------
package gnps_pkg;

	localparam int GRID_SIDE_DEF        = 64;
	localparam int PROBE_DEPTH_DEF      = 4096;
	localparam int CELL_PROBE_LIMIT_DEF = 64;

	localparam logic [1:0] MODE_CELL  = 2'd0;
	localparam logic [1:0] MODE_PROBE = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [2:0] CFG_CELL_SHIFT  = 3'd0;
	localparam logic [2:0] CFG_GRID_MIN_X  = 3'd1;
	localparam logic [2:0] CFG_GRID_MIN_Y  = 3'd2;
	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

	typedef struct packed {
		logic        [4:0]  cell_shift;
		logic signed [15:0] grid_min_x;
		logic signed [15:0] grid_min_y;
		logic        [6:0]  grid_width;
		logic        [6:0]  grid_height;
	} cfg_t;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [11:0] index;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] floor_z;
		logic        [11:0] cell_first;
		logic        [6:0]  cell_count;
		logic        [15:0] red;
		logic        [15:0] green;
		logic        [15:0] blue;
		logic signed [25:0] cx;
		logic signed [25:0] cy;
	} qent_t;

endpackage

[src/grid_nearest_probe_search.sv]
// ----------------------------------------------------------------------------
// grid_nearest_probe_search: nearest probe lookup over a uniform grid
// A write wraps its index into the store depth by repeated subtraction, then stores.
// A query walks the three-by-three cells around its own: a cell outside the grid is
// skipped, a cell inside has its address wrapped and its table entry read, and each
// of its probes then passes the fetch, square and compare loop of the search engine.
// Items are carried out one at a time; a two-entry queue absorbs input bursts.
// Reset clears control and configuration; stores hold nothing until written.
// ----------------------------------------------------------------------------
module grid_nearest_probe_search #(
	parameter int GRID_SIDE        = gnps_pkg::GRID_SIDE_DEF,
	parameter int PROBE_DEPTH      = gnps_pkg::PROBE_DEPTH_DEF,
	parameter int CELL_PROBE_LIMIT = gnps_pkg::CELL_PROBE_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic        [1:0]  mode,
	input  logic        [11:0] index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic signed [23:0] floor_z,
	input  logic        [11:0] cell_first,
	input  logic        [6:0]  cell_count,
	input  logic        [15:0] red_in,
	input  logic        [15:0] green_in,
	input  logic        [15:0] blue_in,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               found,
	output logic        [11:0] probe_index,
	output logic        [15:0] red_out,
	output logic        [15:0] green_out,
	output logic        [15:0] blue_out
);
	import gnps_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	qent_t q_in;
	qent_t q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CELL_SHIFT:  cfg_q.cell_shift  <= cfg_data[4:0];
				CFG_GRID_MIN_X:  cfg_q.grid_min_x  <= cfg_data;
				CFG_GRID_MIN_Y:  cfg_q.grid_min_y  <= cfg_data;
				CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data[6:0];
				CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	gnps_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.index      (index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.floor_z    (floor_z),
		.cell_first (cell_first),
		.cell_count (cell_count),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	gnps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	gnps_back #(
		.GRID_SIDE        (GRID_SIDE),
		.PROBE_DEPTH      (PROBE_DEPTH),
		.CELL_PROBE_LIMIT (CELL_PROBE_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.probe_index  (probe_index),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out)
	);
endmodule

[src/gnps_queue.sv]
// ----------------------------------------------------------------------------
// gnps_queue: two-entry command queue
// Decouples the classifying front end from the search engine.
// ----------------------------------------------------------------------------
module gnps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gnps_pkg::qent_t push_data,
	input  logic           pop,
	output gnps_pkg::qent_t pop_data,
	output logic           full,
	output logic           empty
);
	import gnps_pkg::*;

	qent_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule

[src/gnps_front.sv]
// ----------------------------------------------------------------------------
// gnps_front: input classification
// Drops unused modes and computes the grid column and row of a query.
// ----------------------------------------------------------------------------
module gnps_front (
	input  logic               item_valid,
	output logic               item_stall,
	input  logic        [1:0]  mode,
	input  logic        [11:0] index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic signed [23:0] floor_z,
	input  logic        [11:0] cell_first,
	input  logic        [6:0]  cell_count,
	input  logic        [15:0] red_in,
	input  logic        [15:0] green_in,
	input  logic        [15:0] blue_in,
	input  gnps_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               q_push,
	output gnps_pkg::qent_t    q_data
);
	import gnps_pkg::*;

	logic        [5:0]  sh;
	logic signed [23:0] fx;
	logic signed [23:0] fy;

	// Position carries four fraction bits, so the cell shift grows by four.
	assign sh = {1'b0, cfg.cell_shift} + 6'd4;
	assign fx = pos_x >>> sh;
	assign fy = pos_y >>> sh;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full && (mode != MODE_NONE);

	always_comb begin
		q_data.mode       = mode;
		q_data.index      = index;
		q_data.pos_x      = pos_x;
		q_data.pos_y      = pos_y;
		q_data.pos_z      = pos_z;
		q_data.floor_z    = floor_z;
		q_data.cell_first = cell_first;
		q_data.cell_count = cell_count;
		q_data.red        = red_in;
		q_data.green      = green_in;
		q_data.blue       = blue_in;
		q_data.cx         = 26'(fx) - 26'(cfg.grid_min_x);
		q_data.cy         = 26'(fy) - 26'(cfg.grid_min_y);
	end
endmodule

[src/gnps_back.sv]
// ----------------------------------------------------------------------------
// gnps_back: search engine
// Owns the cell table and probe stores, performs writes and walks queries.
// ----------------------------------------------------------------------------
module gnps_back #(
	parameter int GRID_SIDE        = gnps_pkg::GRID_SIDE_DEF,
	parameter int PROBE_DEPTH      = gnps_pkg::PROBE_DEPTH_DEF,
	parameter int CELL_PROBE_LIMIT = gnps_pkg::CELL_PROBE_LIMIT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gnps_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  gnps_pkg::qent_t q_data,
	output logic            q_pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic            found,
	output logic [11:0]     probe_index,
	output logic [15:0]     red_out,
	output logic [15:0]     green_out,
	output logic [15:0]     blue_out
);
	import gnps_pkg::*;

	localparam int CELL_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int CW  = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int PW  = $clog2(PROBE_DEPTH);
	localparam int RW0 = (PW > CW) ? PW : CW;
	localparam int RW  = (RW0 > 14) ? RW0 : 14;
	localparam int NW0 = $clog2(CELL_PROBE_LIMIT + 1);
	localparam int NW  = (NW0 > 7) ? NW0 : 7;
	localparam logic [RW:0]   CELL_LIM  = (RW+1)'(CELL_DEPTH);
	localparam logic [RW:0]   PROBE_LIM = (RW+1)'(PROBE_DEPTH);
	localparam logic [PW-1:0] P_LAST    = PW'(PROBE_DEPTH - 1);
	localparam logic [NW-1:0] N_LIMIT   = NW'(CELL_PROBE_LIMIT);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RED   = 8'b0000_0010,
		S_CELL  = 8'b0000_0100,
		S_CWAIT = 8'b0000_1000,
		S_PRD   = 8'b0001_0000,
		S_PDAT  = 8'b0010_0000,
		S_PCMP  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {K_WCELL, K_WPROBE, K_RCELL, K_RFIRST} kind_t;

	logic [18:0] cell_mem [CELL_DEPTH];
	logic [23:0] px_mem   [PROBE_DEPTH];
	logic [23:0] py_mem   [PROBE_DEPTH];
	logic [23:0] pz_mem   [PROBE_DEPTH];
	logic [47:0] col_mem  [PROBE_DEPTH];

	state_t      state_q;
	kind_t       kind_q;
	qent_t       cur_q;
	logic [RW-1:0] red_q;
	logic [1:0]  ox_q;
	logic [1:0]  oy_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] i_q;
	logic [PW-1:0] p_q;
	logic [18:0] cell_rd_q;
	logic [23:0] px_rd_q;
	logic [23:0] py_rd_q;
	logic [23:0] pz_rd_q;
	logic [47:0] col_rd_q;
	logic [49:0] sqx_q;
	logic [49:0] sqy_q;
	logic [49:0] sqz_q;
	logic        above_q;
	logic [PW-1:0] cand_p_q;
	logic [47:0] cand_col_q;
	logic        found_q;
	logic [51:0] best_d_q;
	logic [PW-1:0] best_p_q;
	logic [47:0] best_col_q;
	logic        res_valid_q;
	logic        res_found_q;
	logic [11:0] res_idx_q;
	logic [47:0] res_col_q;

	logic [RW:0]        red_lim;
	logic               red_done;
	logic               cell_we;
	logic               cell_re;
	logic               probe_we;
	logic               probe_re;
	logic signed [25:0] gx;
	logic signed [25:0] gy;
	logic               in_grid;
	logic [13:0]        cell_lin;
	logic               last_cell;
	logic [6:0]         raw_cnt;
	logic [NW-1:0]      sat_cnt;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic signed [24:0] dz;
	logic [51:0]        sq_sum;
	logic               out_free;
	logic               res_load;

	assign red_lim  = (kind_q == K_WCELL || kind_q == K_RCELL) ? CELL_LIM : PROBE_LIM;
	assign red_done = {1'b0, red_q} < red_lim;
	assign cell_we  = state_q == S_RED && red_done && kind_q == K_WCELL;
	assign cell_re  = state_q == S_RED && red_done && kind_q == K_RCELL;
	assign probe_we = state_q == S_RED && red_done && kind_q == K_WPROBE;
	assign probe_re = state_q == S_PRD && i_q != cnt_q;

	assign gx        = cur_q.cx + $signed({24'd0, ox_q}) - 26'sd1;
	assign gy        = cur_q.cy + $signed({24'd0, oy_q}) - 26'sd1;
	assign in_grid   = !gx[25] && !gy[25] && gx < $signed({19'd0, cfg.grid_width})
		&& gy < $signed({19'd0, cfg.grid_height});
	assign cell_lin  = 14'(gx[6:0]) + 14'(gy[6:0]) * 14'(cfg.grid_width);
	assign last_cell = ox_q == 2'd2 && oy_q == 2'd2;

	assign raw_cnt = cell_rd_q[18:12];
	assign sat_cnt = (NW'(raw_cnt) > N_LIMIT) ? N_LIMIT : NW'(raw_cnt);

	assign dx     = 25'(signed'(px_rd_q)) - 25'(cur_q.pos_x);
	assign dy     = 25'(signed'(py_rd_q)) - 25'(cur_q.pos_y);
	assign dz     = 25'(signed'(pz_rd_q)) - 25'(cur_q.pos_z);
	assign sq_sum = 52'(sqx_q) + 52'(sqy_q) + 52'(sqz_q);

	assign out_free = !res_valid_q || !result_stall;
	assign res_load = state_q == S_DONE && out_free;
	assign q_pop    = state_q == S_IDLE && !q_empty;

	assign result_valid = res_valid_q;
	assign found        = res_found_q;
	assign probe_index  = res_idx_q;
	assign red_out      = res_col_q[47:32];
	assign green_out    = res_col_q[31:16];
	assign blue_out     = res_col_q[15:0];

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[red_q[CW-1:0]] <= {cur_q.cell_count, cur_q.cell_first};
		if (cell_re) cell_rd_q <= cell_mem[red_q[CW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (probe_we) begin
			px_mem[red_q[PW-1:0]]  <= cur_q.pos_x;
			py_mem[red_q[PW-1:0]]  <= cur_q.pos_y;
			pz_mem[red_q[PW-1:0]]  <= cur_q.pos_z;
			col_mem[red_q[PW-1:0]] <= {cur_q.red, cur_q.green, cur_q.blue};
		end
		if (probe_re) begin
			px_rd_q  <= px_mem[p_q];
			py_rd_q  <= py_mem[p_q];
			pz_rd_q  <= pz_mem[p_q];
			col_rd_q <= col_mem[p_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_WCELL;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_data;
						red_q   <= RW'(q_data.index);
						ox_q    <= 2'd0;
						oy_q    <= 2'd0;
						found_q <= 1'b0;
						if (q_data.mode == MODE_QUERY) begin
							state_q <= S_CELL;
						end else begin
							kind_q  <= (q_data.mode == MODE_CELL) ? K_WCELL : K_WPROBE;
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					// Indexes wrap by repeated subtraction of the store depth.
					if (!red_done) begin
						red_q <= red_q - red_lim[RW-1:0];
					end else begin
						case (kind_q)
							K_RCELL:  state_q <= S_CWAIT;
							K_RFIRST: begin
								p_q     <= red_q[PW-1:0];
								state_q <= S_PRD;
							end
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_CELL: begin
					if (in_grid) begin
						red_q   <= RW'(cell_lin);
						kind_q  <= K_RCELL;
						state_q <= S_RED;
					end else if (last_cell) begin
						state_q <= S_DONE;
					end else if (ox_q == 2'd2) begin
						ox_q <= 2'd0;
						oy_q <= oy_q + 2'd1;
					end else begin
						ox_q <= ox_q + 2'd1;
					end
				end
				S_CWAIT: begin
					cnt_q   <= sat_cnt;
					i_q     <= '0;
					red_q   <= RW'(cell_rd_q[11:0]);
					kind_q  <= K_RFIRST;
					state_q <= S_RED;
				end
				S_PRD: begin
					if (i_q != cnt_q) begin
						state_q <= S_PDAT;
					end else if (last_cell) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CELL;
						if (ox_q == 2'd2) begin
							ox_q <= 2'd0;
							oy_q <= oy_q + 2'd1;
						end else begin
							ox_q <= ox_q + 2'd1;
						end
					end
				end
				S_PDAT: begin
					sqx_q      <= 50'(dx * dx);
					sqy_q      <= 50'(dy * dy);
					sqz_q      <= 50'(dz * dz);
					above_q    <= cur_q.floor_z < signed'(pz_rd_q);
					cand_p_q   <= p_q;
					cand_col_q <= col_rd_q;
					p_q        <= (p_q == P_LAST) ? '0 : p_q + PW'(1);
					i_q        <= i_q + NW'(1);
					state_q    <= S_PCMP;
				end
				S_PCMP: begin
					// Strict compare keeps the earlier probe on a tie.
					if (above_q && (!found_q || sq_sum < best_d_q)) begin
						found_q    <= 1'b1;
						best_d_q   <= sq_sum;
						best_p_q   <= cand_p_q;
						best_col_q <= cand_col_q;
					end
					state_q <= S_PRD;
				end
				S_DONE: begin
					if (out_free) begin
						res_found_q <= found_q;
						res_idx_q   <= found_q ? 12'(best_p_q) : 12'd0;
						res_col_q   <= found_q ? best_col_q : 48'd0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
